// ===== rtl/abst_pkg.sv =====
// Shared types and constants for the array binary search tree.
`default_nettype none

package abst_pkg;

   localparam int KEY_W   = 32;
   localparam int LEVEL_W = 4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_SEARCH = 1'b1
   } mode_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic step;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic walk_stop;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/array_binary_search_tree.sv =====
// Top level of the array binary search tree: controller plus datapath.
`default_nettype none

// Usage
//   Requests arrive on req_valid/req_ready with req_mode (0 insert, 1 search) and the
//   signed req_key. Each request yields one response on rsp_valid/rsp_ready carrying
//   rsp_found, rsp_overflow and rsp_level (level where the walk stopped, masked to 4 bits).
//   Keys live heap-indexed in a single RAM of 2^TREE_LEVELS-1 entries, each entry a key plus
//   its valid bit; the children of node k are 2k+1 (smaller) and 2k+2 (larger).
// Timing
//   The walk visits one level per cycle, bounded by the single RAM read port: the
//   accept cycle reads the root, each walk cycle compares one node and reads the next.
// Reset
//   After reset the block sweeps the RAM, one entry per cycle, clearing every valid bit;
//   req_ready stays low until all 2^TREE_LEVELS-1 entries (255 by default) are cleared.
// Stall
//   The response sits in an output register; while it waits, the next request is still
//   accepted and walked. A finished walk holds in its result register until the output
//   register frees up, and no new request is taken meanwhile.

module array_binary_search_tree #(
   parameter int TREE_LEVELS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_mode,
   input  wire logic signed [abst_pkg::KEY_W-1:0]   req_key,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_found,
   output logic                                     rsp_overflow,
   output logic [abst_pkg::LEVEL_W-1:0]             rsp_level
);

   // Command and status between controller and datapath.
   abst_pkg::cmd_type    cmd;
   abst_pkg::status_type status;

   // Sequence clear, accept, walk and hand-off.
   abst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the node RAM, the walk registers and the output register.
   abst_dp #(
      .TREE_LEVELS (TREE_LEVELS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_found    (rsp_found),
      .rsp_overflow (rsp_overflow),
      .rsp_level    (rsp_level)
   );

endmodule

`default_nettype wire

// ===== rtl/abst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module abst_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 255,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/abst_ctrl.sv =====
// Controller state machine: clearing pass, request accept, tree walk, response hand-off.
`default_nettype none

module abst_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire abst_pkg::status_type status,
   output abst_pkg::cmd_type         cmd
);

   abst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abst_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         abst_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = abst_pkg::ST_IDLE;
            end
         end
         abst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = abst_pkg::ST_WALK;
            end
         end
         abst_pkg::ST_WALK: begin
            cmd.step = 1'b1;
            if (status.walk_stop) begin
               state_in = abst_pkg::ST_DONE;
            end
         end
         abst_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.deliver = 1'b1;
               state_in    = abst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abst_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/abst_dp.sv =====
// Datapath: node RAM, walk registers, compare and result/output registers.
`default_nettype none

module abst_dp #(
   parameter int TREE_LEVELS = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire abst_pkg::cmd_type                cmd,
   output abst_pkg::status_type                  status,
   input  wire logic                             req_mode,
   input  wire logic signed [abst_pkg::KEY_W-1:0] req_key,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_found,
   output logic                                  rsp_overflow,
   output logic [abst_pkg::LEVEL_W-1:0]          rsp_level
);

   localparam int NODE_COUNT = (2 ** TREE_LEVELS) - 1;
   localparam int NODE_W     = TREE_LEVELS;
   localparam int LVL_W      = $clog2(TREE_LEVELS + 1);
   localparam int ENTRY_W    = abst_pkg::KEY_W + 1;

   logic                         mode_ff;
   logic [abst_pkg::KEY_W-1:0]   key_ff;
   logic [NODE_W-1:0]            node_ff, node_in;
   logic [LVL_W-1:0]             lvl_ff, lvl_in, lvl_nxt;
   logic [NODE_W-1:0]            clr_ff, clr_in;

   logic                         res_found_ff, res_found_in;
   logic                         res_ovf_ff, res_ovf_in;
   logic [LVL_W-1:0]             res_lvl_ff, res_lvl_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_ovf_ff;
   logic [abst_pkg::LEVEL_W-1:0] rsp_level_ff;
   logic [LVL_W+abst_pkg::LEVEL_W-1:0] lvl_ext;

   logic                         wr_en, rd_en;
   logic [NODE_W-1:0]            wr_addr, rd_addr;
   logic [ENTRY_W-1:0]           wr_data, rd_data;

   logic                         node_vld, key_hit, go_left, last_lvl, stop;
   logic [NODE_W-1:0]            node_nxt;

   // Node compare on the registered read of the current node.
   assign node_vld = rd_data[ENTRY_W-1];
   assign key_hit  = (rd_data[abst_pkg::KEY_W-1:0] == key_ff);
   assign go_left  = $signed(rd_data[abst_pkg::KEY_W-1:0]) > $signed(key_ff);
   assign lvl_nxt  = lvl_ff + 1'b1;
   assign last_lvl = (lvl_nxt == LVL_W'(TREE_LEVELS));
   assign node_nxt = (node_ff << 1) + (go_left ? NODE_W'(1) : NODE_W'(2));
   assign stop     = !node_vld || key_hit || last_lvl;

   always_comb begin
      node_in      = node_ff;
      lvl_in       = lvl_ff;
      res_found_in = res_found_ff;
      res_ovf_in   = res_ovf_ff;
      res_lvl_in   = res_lvl_ff;
      if (cmd.start) begin
         node_in = '0;
         lvl_in  = '0;
      end else if (cmd.step) begin
         if (!node_vld) begin
            res_found_in = 1'b0;
            res_ovf_in   = 1'b0;
            res_lvl_in   = lvl_ff;
         end else if (key_hit) begin
            res_found_in = 1'b1;
            res_ovf_in   = 1'b0;
            res_lvl_in   = lvl_ff;
         end else if (last_lvl) begin
            res_found_in = 1'b0;
            res_ovf_in   = (mode_ff == abst_pkg::MODE_INSERT);
            res_lvl_in   = lvl_nxt;
         end else begin
            node_in = node_nxt;
            lvl_in  = lvl_nxt;
         end
      end
   end

   // RAM ports: clearing pass, root read on accept, child read and insert write while walking.
   always_comb begin
      rd_en   = cmd.start || (cmd.step && !stop);
      rd_addr = cmd.start ? '0 : node_nxt;
      wr_en   = cmd.clear || (cmd.step && !node_vld && (mode_ff == abst_pkg::MODE_INSERT));
      wr_addr = cmd.clear ? clr_ff : node_ff;
      wr_data = cmd.clear ? '0 : {1'b1, key_ff};
   end

   assign clr_in = cmd.clear ? clr_ff + 1'b1 : clr_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign lvl_ext = {{abst_pkg::LEVEL_W{1'b0}}, res_lvl_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      node_ff      <= node_in;
      lvl_ff       <= lvl_in;
      res_found_ff <= res_found_in;
      res_ovf_ff   <= res_ovf_in;
      res_lvl_ff   <= res_lvl_in;
      if (cmd.deliver) begin
         rsp_found_ff <= res_found_ff;
         rsp_ovf_ff   <= res_ovf_ff;
         rsp_level_ff <= lvl_ext[abst_pkg::LEVEL_W-1:0];
      end
   end

   abst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT),
      .AW    (NODE_W)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.clear_last = (clr_ff == NODE_W'(NODE_COUNT - 1));
   assign status.walk_stop  = stop;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_ovf_ff;
   assign rsp_level    = rsp_level_ff;

   a_walk_level_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (lvl_ff < LVL_W'(TREE_LEVELS)))
      else $error("walk level beyond last tree level");

   a_write_only_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && wr_en) |-> !node_vld)
      else $error("insert overwrites an occupied node");

   a_no_found_and_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_ovf_ff))
      else $error("response flags both found and overflow");

   a_deliver_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |=> rsp_valid_ff)
      else $error("delivered response not presented");

endmodule

`default_nettype wire

// ===== tb/tb_array_binary_search_tree.sv =====
// Self-checking testbench for the array binary search tree: scoreboard, stimulus, checks.
`timescale 1ns / 1ps

module tb_array_binary_search_tree;

   localparam int TREE_LEVELS = 8;
   localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;

   // Keys at the ends of the signed range, and all ones (-1)
   localparam logic [abst_pkg::KEY_W-1:0] KEY_MOST_NEG = 32'h8000_0000;
   localparam logic [abst_pkg::KEY_W-1:0] KEY_MOST_POS = 32'h7FFF_FFFF;
   localparam logic [abst_pkg::KEY_W-1:0] KEY_ALL_ONES = 32'hFFFF_FFFF;

   // Run control
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request or response moving
   localparam int HOLD_CYCLES    = 300;   // long output hold-off
   localparam int DRAIN_CYCLES   = 2 * (TREE_LEVELS + 2);
   localparam int POOL_MAX       = 300;

   typedef struct packed {
      logic                           found;
      logic                           overflow;
      logic [abst_pkg::LEVEL_W-1:0]   level;
   } walk_result_type;

   // Shadow tree plus the queue of walk results still owed by the block
   class tree_scoreboard;
      logic signed [abst_pkg::KEY_W-1:0] key_at[NODE_COUNT];
      bit                                used[NODE_COUNT];
      walk_result_type                   owed_q[$];
      int                                errors;
      int                                requests;
      int                                hits;
      int                                overflows;

      function new();
         foreach (used[i]) used[i] = 1'b0;
         errors    = 0;
         requests  = 0;
         hits      = 0;
         overflows = 0;
      endfunction

      // Walk the shadow tree for an accepted request and queue the outcome
      function void note_request(abst_pkg::mode_type mode,
                                 logic signed [abst_pkg::KEY_W-1:0] key);
         int              node;
         int              lvl;
         walk_result_type res;
         node = 0;
         lvl  = 0;
         res  = '0;
         while (lvl < TREE_LEVELS && node < NODE_COUNT) begin
            if (!used[node]) begin
               if (mode == abst_pkg::MODE_INSERT) begin
                  key_at[node] = key;
                  used[node]   = 1'b1;
               end
               break;
            end
            if (key_at[node] == key) begin
               res.found = 1'b1;
               break;
            end
            if (key_at[node] > key) node = 2 * node + 1;
            else node = 2 * node + 2;
            lvl++;
         end
         res.overflow = (lvl >= TREE_LEVELS) && (mode == abst_pkg::MODE_INSERT);
         res.level    = lvl[abst_pkg::LEVEL_W-1:0];
         requests++;
         if (res.found) hits++;
         if (res.overflow) overflows++;
         owed_q.push_back(res);
      endfunction

      function void check_response(logic found, logic overflow,
                                   logic [abst_pkg::LEVEL_W-1:0] level);
         walk_result_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected response found=%0b overflow=%0b level=%0d",
                     $time, found, overflow, level);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (found !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, found);
            errors++;
         end
         if (overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b actual %0b",
                     $time, want.overflow, overflow);
            errors++;
         end
         if (level !== want.level) begin
            $display("%0t: level mismatch, expected %0d actual %0d", $time, want.level, level);
            errors++;
         end
      endfunction

      function int owed_count();
         return owed_q.size();
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_mode;
   logic signed [abst_pkg::KEY_W-1:0]   req_key;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic                                rsp_found;
   logic                                rsp_overflow;
   logic [abst_pkg::LEVEL_W-1:0]        rsp_level;

   tree_scoreboard                      sb;

   // Idle and stall rates, in percent, set per phase by the main sequence
   int                                  send_idle_pct;
   int                                  recv_stall_pct;
   bit                                  hold_request;
   int                                  holds_done;
   int                                  idle_cycles;

   // The most recent keys issued (up to POOL_MAX), reused to hit stored nodes and their neighbors
   logic signed [abst_pkg::KEY_W-1:0]   key_pool[$];

   array_binary_search_tree #(
      .TREE_LEVELS(TREE_LEVELS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_found    (rsp_found),
      .rsp_overflow (rsp_overflow),
      .rsp_level    (rsp_level)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor and watchdog: sample both handshakes at the rising edge. The request is
   // noted first; its response can never come in the same cycle.
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         sb.note_request(abst_pkg::mode_type'(req_mode), req_key);
      end
      if (rsp_valid && rsp_ready) begin
         sb.check_response(rsp_found, rsp_overflow, rsp_level);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d responses still owed", $time, sb.owed_count());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: drop ready at random per phase; on a hold request keep ready low for a
   // long stretch so the block fills up and stalls its input.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            holds_done   = holds_done + 1;
            rsp_ready   <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one request and hold it until accepted. Call and return at a falling edge.
   task automatic send_request(input abst_pkg::mode_type mode,
                               input logic signed [abst_pkg::KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (key_pool.size() >= POOL_MAX) void'(key_pool.pop_front());
      key_pool.push_back(key);
   endtask

   function automatic logic signed [abst_pkg::KEY_W-1:0] pool_key();
      if (key_pool.size() == 0) return $urandom;
      return key_pool[$urandom_range(key_pool.size() - 1)];
   endfunction

   // A recently issued key nudged by 1 to 4, to land right next to existing nodes
   function automatic logic signed [abst_pkg::KEY_W-1:0] near_key();
      logic signed [abst_pkg::KEY_W-1:0] base;
      logic signed [abst_pkg::KEY_W-1:0] delta;
      base  = pool_key();
      delta = $urandom_range(4, 1);
      return $urandom_range(1) ? base + delta : base - delta;
   endfunction

   // Random traffic: inserts and searches of recently issued keys and keys right next to them,
   // so walks run deep and hit; the rest, just under half, are fresh keys.
   task automatic send_random(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 35) send_request(abst_pkg::MODE_INSERT, $urandom);
         else if (pick < 50) send_request(abst_pkg::MODE_INSERT, pool_key());
         else if (pick < 58) send_request(abst_pkg::MODE_INSERT, near_key());
         else if (pick < 80) send_request(abst_pkg::MODE_SEARCH, pool_key());
         else if (pick < 90) send_request(abst_pkg::MODE_SEARCH, near_key());
         else send_request(abst_pkg::MODE_SEARCH, $urandom);
      end
   endtask

   initial begin
      sb             = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      holds_done     = 0;
      idle_cycles    = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = abst_pkg::MODE_INSERT;
      req_key        = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty tree, root, duplicates, a bisection spine down to overflow,
      // and the extreme keys. The spine narrows to a tiny interval so random keys
      // rarely fall into it.
      send_request(abst_pkg::MODE_SEARCH, 32'sd5);        // search on empty tree
      send_request(abst_pkg::MODE_INSERT, 32'sd0);        // root
      send_request(abst_pkg::MODE_INSERT, 32'sd0);        // duplicate at root
      send_request(abst_pkg::MODE_INSERT, 32'h4000_0000);
      send_request(abst_pkg::MODE_INSERT, 32'h2000_0000);
      send_request(abst_pkg::MODE_INSERT, 32'h3000_0000);
      send_request(abst_pkg::MODE_INSERT, 32'h2800_0000);
      send_request(abst_pkg::MODE_INSERT, 32'h2C00_0000);
      send_request(abst_pkg::MODE_INSERT, 32'h2A00_0000);
      send_request(abst_pkg::MODE_INSERT, 32'h2B00_0000);  // last level
      send_request(abst_pkg::MODE_INSERT, 32'h2A80_0000);  // past the last level: dropped
      send_request(abst_pkg::MODE_SEARCH, 32'h2A80_0000);  // search past the last level
      send_request(abst_pkg::MODE_SEARCH, 32'h2C00_0000);  // deep hit
      send_request(abst_pkg::MODE_INSERT, KEY_MOST_NEG);   // most negative is a plain key
      send_request(abst_pkg::MODE_SEARCH, KEY_MOST_NEG);
      send_request(abst_pkg::MODE_INSERT, KEY_MOST_POS);
      send_request(abst_pkg::MODE_INSERT, KEY_ALL_ONES);
      send_request(abst_pkg::MODE_INSERT, KEY_ALL_ONES);   // duplicate below the root
      send_request(abst_pkg::MODE_SEARCH, 32'sd1);         // search ends on empty node
      send_request(abst_pkg::MODE_SEARCH, KEY_MOST_POS - 1);

      // Phase: no idling on either side
      send_random(200);

      // Phase: long output hold while requests keep coming
      hold_request = 1'b1;
      send_random(50);

      // Phase: sender idle most of the time
      send_idle_pct = 75;
      send_random(200);

      // Phase: receiver stalling most of the time
      send_idle_pct  = 0;
      recv_stall_pct = 75;
      send_random(200);

      // Phase: light idling on both sides
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      send_random(200);

      // Drain: drop valid and let every owed response come back
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (sb.owed_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d requests walked, %0d hit a stored key, %0d inserts dropped",
               sb.requests, sb.hits, sb.overflows);
      $display("Summary: idle phases none/sender/receiver/both, %0d long output hold(s)",
               holds_done);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/abst_pkg.sv
rtl/abst_ram.sv
rtl/abst_ctrl.sv
rtl/abst_dp.sv
rtl/array_binary_search_tree.sv
tb/tb_array_binary_search_tree.sv
